>>> hdl/duff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duff_pkg
// Shared constants and types for the Duffing oscillator step unit.
// ----------------------------------------------------------------------------
package duff_pkg;

  localparam int FRAC_BITS     = 24;
  localparam int COSINE_STAGES = 20;
  localparam int CORDIC_MAX    = 30;
  localparam int STG_W         = $clog2(CORDIC_MAX + 1);

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // configuration register indexes
  localparam logic [2:0] REG_DAMPING_A  = 3'd0;
  localparam logic [2:0] REG_FORCING_B  = 3'd1;
  localparam logic [2:0] REG_PHASE_STEP = 3'd2;
  localparam logic [2:0] REG_TIME_STEP  = 3'd3;
  localparam logic [2:0] REG_INIT_X     = 3'd4;
  localparam logic [2:0] REG_INIT_Y     = 3'd5;
  localparam logic [2:0] REG_INIT_PHASE = 3'd6;

  // arctangent table in turns scaled by 2^32
  function automatic logic signed [33:0] atan_turns(input logic [STG_W-1:0] idx);
    logic signed [33:0] v;
    v = '0;
    case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // cordic control from sequencer to rotator
  typedef struct packed {
    logic             start;
    logic [31:0]      phase;
  } cordic_req_t;

  typedef struct packed {
    logic             done;
    logic signed [31:0] cos_val;
  } cordic_rsp_t;

endpackage

>>> hdl/duffing_oscillator_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duffing_oscillator_step_unit
// Forced Duffing oscillator, one forward-Euler step per integration item.
// ----------------------------------------------------------------------------
// An integration item starts the CORDIC cosine. Meanwhile the shared 32x32
// multiplier forms x*x, a*y, x^2*x and y*dt. After the cosine, b*cos and
// sum*dt run in sequence, followed by the state update and the output
// valid; the result shown is the state held when the item was accepted. A
// restart item loads the initial state and goes straight to the output. The
// block takes one item at a time; the result waits in an output register,
// and in_stall is high until it is taken.
module duffing_oscillator_step_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out
);
  import duff_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_WAIT = 6'b000100,
    S_BC   = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  // configuration registers
  logic signed [31:0] damp_a_r, force_b_r, dt_r, init_x_r, init_y_r;
  logic [31:0]        ph_step_r, init_ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_a_r  <= 32'sd4194304;
      force_b_r <= 32'sd5033165;
      ph_step_r <= 32'd615208748;
      dt_r      <= 32'sd15099494;
      init_x_r  <= 32'sd1677722;
      init_y_r  <= 32'sd1677722;
      init_ph_r <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DAMPING_A:  damp_a_r  <= cfg_data;
        REG_FORCING_B:  force_b_r <= cfg_data;
        REG_PHASE_STEP: ph_step_r <= cfg_data;
        REG_TIME_STEP:  dt_r      <= cfg_data;
        REG_INIT_X:     init_x_r  <= cfg_data;
        REG_INIT_Y:     init_y_r  <= cfg_data;
        REG_INIT_PHASE: init_ph_r <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic signed [31:0] x_r, x_nxt, y_r, y_nxt;
  logic [31:0]        ph_r, ph_nxt;
  logic signed [31:0] x2_r, x2_nxt, x3_r, x3_nxt, ay_r, ay_nxt, bc_r, bc_nxt;
  logic signed [31:0] sum_r, sum_nxt, ydt_r, ydt_nxt;
  logic [2:0]         op_r, op_nxt;
  logic               cos_ok_r, cos_ok_nxt;
  logic signed [31:0] cos_r, cos_nxt;
  logic signed [31:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic               ov_r, ov_nxt;

  cordic_req_t creq;
  cordic_rsp_t crsp;

  duff_cordic u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (creq),
    .rsp  (crsp)
  );

  // shared multiplier: operands by op, product registered
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_r;
  logic signed [31:0] mq;
  logic signed [65:0] sumw;
  logic               accept;

  always_comb begin
    ma = x_r;
    mb = x_r;
    case (op_r)
      3'd1: begin ma = x2_r;      mb = x_r;  end
      3'd2: begin ma = damp_a_r;  mb = y_r;  end
      3'd3: begin ma = y_r;       mb = dt_r; end
      3'd4: begin ma = force_b_r; mb = cos_r; end
      3'd5: begin ma = sum_r;     mb = dt_r; end
      default: begin ma = x_r;    mb = x_r;  end
    endcase
  end

  always_ff @(posedge clk) prod_r <= ma * mb;

  assign mq     = sat32($signed({{2{prod_r[63]}}, prod_r}) >>> FRAC_BITS);
  assign accept = in_valid && !in_stall;

  // sequencer: op_r selects the product issued this cycle
  always_comb begin
    state_nxt  = state_r;
    x_nxt = x_r; y_nxt = y_r; ph_nxt = ph_r;
    x2_nxt = x2_r; x3_nxt = x3_r; ay_nxt = ay_r; bc_nxt = bc_r;
    sum_nxt = sum_r; ydt_nxt = ydt_r;
    op_nxt = op_r;
    cos_ok_nxt = cos_ok_r; cos_nxt = cos_r;
    ox_nxt = ox_r; oy_nxt = oy_r; ov_nxt = ov_r;
    creq.start = 1'b0;
    creq.phase = ph_r + ph_step_r;
    sumw = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (crsp.done) begin
      cos_ok_nxt = 1'b1;
      cos_nxt    = crsp.cos_val;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_restart) begin
            x_nxt  = init_x_r;
            y_nxt  = init_y_r;
            ph_nxt = init_ph_r;
            ox_nxt = init_x_r;
            oy_nxt = init_y_r;
            state_nxt = S_OUT;
          end else begin
            ox_nxt = x_r;
            oy_nxt = y_r;
            creq.start = 1'b1;
            ph_nxt = ph_r + ph_step_r;
            cos_ok_nxt = 1'b0;
            op_nxt = 3'd0;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        // issue order x*x, a*y, x2*x, y*dt so x2_r is loaded before x2*x
        case (op_r)
          3'd2: x2_nxt = mq;
          3'd1: ay_nxt = mq;
          3'd3: x3_nxt = mq;
          default: ;
        endcase
        if (op_r == 3'd0) begin
          op_nxt = 3'd2;
        end else if (op_r == 3'd2) begin
          op_nxt = 3'd1;
        end else if (op_r == 3'd1) begin
          op_nxt = 3'd3;
        end else begin
          op_nxt = 3'd4;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (op_r == 3'd4) ydt_nxt = mq;
        op_nxt = 3'd7;
        if (cos_ok_r) begin
          op_nxt = 3'd4;
          state_nxt = S_BC;
        end
      end
      S_BC: begin
        // b*cos issuing; next cycle its product is ready
        op_nxt = 3'd6;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (op_r == 3'd6) begin
          bc_nxt = mq;
          sumw = {{34{x_r[31]}}, x_r} - {{34{x3_r[31]}}, x3_r}
               - {{34{ay_r[31]}}, ay_r} + {{34{mq[31]}}, mq};
          sum_nxt = sat32(sumw);
          op_nxt = 3'd5;
        end else if (op_r == 3'd5) begin
          op_nxt = 3'd0;
        end else begin
          sumw  = {{34{x_r[31]}}, x_r} + {{34{ydt_r[31]}}, ydt_r};
          x_nxt = sat32(sumw);
          sumw  = {{34{y_r[31]}}, y_r} + {{34{mq[31]}}, mq};
          y_nxt = sat32(sumw);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      x_r      <= 32'sd1677722;
      y_r      <= 32'sd1677722;
      ph_r     <= 32'd0;
      ov_r     <= 1'b0;
      cos_ok_r <= 1'b0;
      op_r     <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      ph_r     <= ph_nxt;
      ov_r     <= ov_nxt;
      cos_ok_r <= cos_ok_nxt;
      op_r     <= op_nxt;
    end
    x2_r <= x2_nxt; x3_r <= x3_nxt; ay_r <= ay_nxt; bc_r <= bc_nxt;
    sum_r <= sum_nxt; ydt_r <= ydt_nxt; cos_r <= cos_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt;
  end

  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_x_out = ox_r;
  assign out_y_out = oy_r;

`ifndef SYNTHESIS
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == S_IDLE) else $error("item taken while busy");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r) == S_OUT) else $error("result out of sequence");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("ready while busy");
`endif

endmodule

>>> hdl/duff_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duff_cordic
// Iterative CORDIC cosine, one rotation per cycle, result in Q8.24 style.
// ----------------------------------------------------------------------------
module duff_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  duff_pkg::cordic_req_t req,
  output duff_pkg::cordic_rsp_t rsp
);
  import duff_pkg::*;

  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt, z_r, z_nxt;
  logic [STG_W-1:0]   i_r, i_nxt;
  logic               busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic [31:0]        u;
  logic               neg_in;
  logic signed [33:0] tx, ty, cx_sh;

  localparam int LAST = (COSINE_STAGES < CORDIC_MAX ? COSINE_STAGES : CORDIC_MAX) - 1;

  // fold angle and rotate
  always_comb begin
    neg_in  = ((req.phase + 32'h40000000) & 32'h80000000) != 32'd0;
    u       = neg_in ? req.phase + 32'h80000000 : req.phase;
    tx      = cx_r >>> i_r;
    ty      = cy_r >>> i_r;
    cx_sh   = '0;
    cx_nxt  = cx_r;
    cy_nxt  = cy_r;
    z_nxt   = z_r;
    i_nxt   = i_r;
    busy_nxt = busy_r;
    neg_nxt = neg_r;
    done_nxt = 1'b0;
    res_nxt = res_r;
    if (req.start) begin
      cx_nxt  = CORDIC_GAIN;
      cy_nxt  = '0;
      z_nxt   = {{2{u[31]}}, u};
      i_nxt   = '0;
      neg_nxt = neg_in;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[33]) begin
        cx_nxt = cx_r - ty;
        cy_nxt = cy_r + tx;
        z_nxt  = z_r - atan_turns(i_r);
      end else begin
        cx_nxt = cx_r + ty;
        cy_nxt = cy_r - tx;
        z_nxt  = z_r + atan_turns(i_r);
      end
      if (i_r == STG_W'(LAST)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        cx_sh    = cx_nxt >>> (30 - FRAC_BITS);
        res_nxt  = neg_r ? -cx_sh[31:0] : cx_sh[31:0];
      end else begin
        i_nxt = i_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    z_r   <= z_nxt;
    i_r   <= i_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.cos_val = res_r;

endmodule

>>> tb/tb_duffing_oscillator_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_duffing_oscillator_step_unit
// Self-checking bench for the Duffing oscillator step unit. A driver and a
// monitor run the valid/stall channels with random idling. A fixed-point
// Duffing and CORDIC model inside the bench predicts x and y for every
// accepted item. Phases go through reset, extreme and random register sets.
// ----------------------------------------------------------------------------
module tb_duffing_oscillator_step_unit;
  import duff_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int RUN_LIMIT = 800000;
  localparam int HOLD_LEN = 400;
  localparam longint CORDIC_K = 652032874;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall, in_restart;
  logic out_valid, out_stall;
  logic signed [31:0] out_x_out, out_y_out;

  duffing_oscillator_step_unit DUT (.*);

  // model copy of registers and state
  longint damp_a, force_b, dt, start_x, start_y;
  logic [31:0] ph_inc, start_ph;
  longint osc_x, osc_y;
  logic [31:0] osc_ph;

  bit item_q[$];
  logic signed [31:0] want_x[$], want_y[$];
  int send_idle, recv_idle;
  bit hold_on;
  int hold_cnt;
  int errors, n_items, n_results, n_restarts, cycles;

  longint arctan_tbl[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return clip32(p >>> FRAC_BITS);
  endfunction

  // cordic cosine with the angle folded into the right half plane
  function automatic longint fx_cos(logic [31:0] ph);
    logic [31:0] u;
    bit flip;
    longint cx, cy, z, tx, ty;
    u = ph;
    flip = ((u + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (flip) u = u + 32'h8000_0000;
    z = longint'(signed'(u));
    cx = CORDIC_K;
    cy = 0;
    for (int i = 0; i < COSINE_STAGES && i < 30; i++) begin
      tx = cx >>> i;
      ty = cy >>> i;
      if (z >= 0) begin
        cx = cx - ty; cy = cy + tx; z = z - arctan_tbl[i];
      end else begin
        cx = cx + ty; cy = cy - tx; z = z + arctan_tbl[i];
      end
    end
    cx = cx >>> (30 - FRAC_BITS);
    return flip ? -cx : cx;
  endfunction

  // one tick of the oscillator; returns the position and velocity shown
  function automatic void duffing_tick(bit restart, output logic signed [31:0] xo,
                                       output logic signed [31:0] yo);
    longint x, y, x3, ay, bc, sum;
    if (restart) begin
      osc_x = start_x; osc_y = start_y; osc_ph = start_ph;
      xo = osc_x[31:0]; yo = osc_y[31:0];
      return;
    end
    xo = osc_x[31:0]; yo = osc_y[31:0];
    x = osc_x; y = osc_y;
    osc_ph = osc_ph + ph_inc;
    x3 = fx_mul(fx_mul(x, x), x);
    ay = fx_mul(damp_a, y);
    bc = fx_mul(force_b, fx_cos(osc_ph));
    sum = clip32(x - x3 - ay + bc);
    osc_x = clip32(x + fx_mul(y, dt));
    osc_y = clip32(y + fx_mul(sum, dt));
  endfunction

  // driver: offers queued items, holds a stalled item
  always @(posedge clk) begin
    logic signed [31:0] ex, ey;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        duffing_tick(in_restart, ex, ey);
        want_x.push_back(ex);
        want_y.push_back(ey);
        n_items++;
        if (in_restart) n_restarts++;
      end
      if (!in_valid || !in_stall) begin
        if (item_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_restart <= item_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall, one long hold-off, compare with oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (want_x.size() == 0) begin
          $error("result with no item pending: x=%0d y=%0d", out_x_out, out_y_out);
          errors++;
        end else begin
          if (out_x_out !== want_x[0]) begin
            $error("x_out expected %0d actual %0d", want_x[0], out_x_out);
            errors++;
          end
          if (out_y_out !== want_y[0]) begin
            $error("y_out expected %0d actual %0d", want_y[0], out_y_out);
            errors++;
          end
          void'(want_x.pop_front());
          void'(want_y.pop_front());
        end
      end
      if (hold_on && hold_cnt < HOLD_LEN) begin
        hold_cnt++;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DAMPING_A:  damp_a = longint'(signed'(val));
      REG_FORCING_B:  force_b = longint'(signed'(val));
      REG_PHASE_STEP: ph_inc = val;
      REG_TIME_STEP:  dt = longint'(signed'(val));
      REG_INIT_X:     start_x = longint'(signed'(val));
      REG_INIT_Y:     start_y = longint'(signed'(val));
      REG_INIT_PHASE: start_ph = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (item_q.size() > 0 || in_valid || want_x.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] a, logic [31:0] b, logic [31:0] ps,
                           logic [31:0] t, logic [31:0] ix, logic [31:0] iy,
                           logic [31:0] ip);
    write_reg(REG_DAMPING_A, a);
    write_reg(REG_FORCING_B, b);
    write_reg(REG_PHASE_STEP, ps);
    write_reg(REG_TIME_STEP, t);
    write_reg(REG_INIT_X, ix);
    write_reg(REG_INIT_Y, iy);
    write_reg(REG_INIT_PHASE, ip);
  endtask

  // random burst: restart first, then mostly integration steps
  task automatic random_phase(int count, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    item_q.push_back(1'b1);
    for (int i = 1; i < count; i++) item_q.push_back($urandom_range(39) == 0);
    drain();
  endtask

  initial begin
    int mode;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_restart = 1'b0; out_stall = 1'b0;
    send_idle = 0; recv_idle = 0; hold_on = 1'b0; hold_cnt = 0;
    errors = 0; n_items = 0; n_results = 0; n_restarts = 0; cycles = 0;
    damp_a = 4194304; force_b = 5033165; ph_inc = 32'd615208748; dt = 15099494;
    start_x = 1677722; start_y = 1677722; start_ph = '0;
    osc_x = 1677722; osc_y = 1677722; osc_ph = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: steps from reset state, restart, steps, two restarts
    for (int i = 0; i < 6; i++) item_q.push_back(i == 3);
    item_q.push_back(1'b1);
    item_q.push_back(1'b1);
    drain();

    // unused index must change nothing
    write_reg(REG_UNUSED, 32'hffff_ffff);
    for (int i = 0; i < 3; i++) item_q.push_back(1'b0);
    drain();

    // extremes: saturation everywhere, phase wrap
    write_all(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h8000_0000, 32'h4000_0000);
    for (int i = 0; i < 5; i++) item_q.push_back(i == 0);
    drain();
    write_all(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7fff_ffff, 32'hc000_0000);
    for (int i = 0; i < 5; i++) item_q.push_back(i == 0);
    drain();
    write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
    for (int i = 0; i < 3; i++) item_q.push_back(i == 0);
    drain();

    // long hold-off on the result side while items keep coming
    write_all(32'd4194304, 32'd5033165, 32'd615208748, 32'd15099494,
              32'd1677722, 32'd1677722, 32'd0);
    hold_on = 1'b1;
    random_phase(30, 0, 0);
    hold_on = 1'b0;

    // random register sets across idling modes
    for (int p = 0; p < 28; p++) begin
      mode = p % 4;
      if (p % 5 == 4) begin
        write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
      end else begin
        write_all($urandom_range(8388608), $urandom_range(33554432) - 16777216,
                  $urandom, $urandom_range(2000000, 100000),
                  $urandom_range(50331648) - 25165824,
                  $urandom_range(50331648) - 25165824, $urandom);
      end
      case (mode)
        0: random_phase(50, 0, 0);
        1: random_phase(50, 68, 0);
        2: random_phase(50, 0, 68);
        default: random_phase(50, 7, 7);
      endcase
    end

    $display("covered %0d items (%0d restarts), %0d results checked, %0d cycles",
             n_items, n_restarts, n_results, cycles);
    $display("register sets: reset, both extremes, zero, 28 random; one long hold-off");
    if (errors == 0 && want_x.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
